// ===== sv/bnum_pkg.sv =====
// Package for the nearest unique barcode match block.
// Holds sizes, request and result types, codes and controller/datapath links.
// No dependencies.
package bnum_pkg;

  localparam int unsigned TABLE_DEPTH   = 4096;
  localparam int unsigned BARCODE_BASES = 16;
  localparam int unsigned BASE_W        = 3;
  localparam int unsigned BARCODE_W     = BASE_W * BARCODE_BASES;
  localparam int unsigned ADDR_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned INDEX_W       = 12;
  localparam int unsigned DIST_W        = 5;
  localparam int unsigned ENTRIES_W     = 13;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned CMP_W         = (CNT_W > INDEX_W) ?
                                          ((CNT_W > ENTRIES_W) ? CNT_W : ENTRIES_W) :
                                          ((INDEX_W > ENTRIES_W) ? INDEX_W : ENTRIES_W);

  localparam logic [DIST_W-1:0]    MAX_DIST_RESET = DIST_W'(2);
  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET  = '0;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_DISTANCE   = 1'b0,
    REG_ENTRIES_IN_USE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                 opcode;
    logic [INDEX_W-1:0]   entry_index;
    logic [BARCODE_W-1:0] barcode_bases;
  } in_req_t;

  typedef struct packed {
    logic               match_found;
    logic [INDEX_W-1:0] match_index;
    logic [DIST_W-1:0]  best_distance;
  } out_rsp_t;

  typedef struct packed {
    logic write;
    logic start;
    logic issue;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_issue;
    logic busy;
  } dp_sts_t;

endpackage

// ===== sv/barcode_nearest_unique_match.sv =====
// Top level of the nearest unique barcode match block.
// Joins bnum_ctrl and bnum_dp; depends on bnum_pkg.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | in_req_i  (bnum_pkg::in_req_t)
//   out     | output    | out_valid_o/out_ready_i | out_rsp_o (bnum_pkg::out_rsp_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A load request writes one whitelist entry and gives no result.
// A query request scans min(entries_in_use, TABLE_DEPTH) whitelist entries, none if that is
// zero: the scan reads one whitelist entry per cycle from the table's read port.
// A finished result waits in the output register; the next request is taken
// meanwhile, and a later query holds in its last state until the result leaves.
// Reset clears control and settings only; the table holds no reset state.
module barcode_nearest_unique_match (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bnum_pkg::in_req_t               in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bnum_pkg::out_rsp_t              out_rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bnum_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bnum_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  bnum_pkg::dp_cmd_t cmd;
  bnum_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  bnum_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_opcode_i (in_req_i.opcode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bnum_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_rsp_o   (out_rsp_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.opcode == bnum_pkg::OP_QUERY) |=> !in_ready_o)
    else $error("query accepted without starting a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.match_found |->
      (out_rsp_o.match_index == '0) && (out_rsp_o.best_distance == '0))
    else $error("no-match result carries non-zero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised without a finished scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !cmd.load_out && !cmd.start)
    else $error("scan read overlaps start or result load");
`endif

endmodule

// ===== sv/bnum_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bnum_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bnum_ctrl.sv =====
// Controller for the nearest unique barcode match block.
// Sequences load, scan, drain and result hand-off; depends on bnum_pkg.
module bnum_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_opcode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bnum_pkg::dp_cmd_t cmd_o,
  input  bnum_pkg::dp_sts_t sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.write    = accept && (in_opcode_i == bnum_pkg::OP_LOAD);
    cmd_o.start    = accept && (in_opcode_i == bnum_pkg::OP_QUERY);
    cmd_o.issue    = (state_q == ST_SCAN) && !sts_i.count_zero;
    cmd_o.load_out = (state_q == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.start) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts_i.count_zero || sts_i.last_issue) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!sts_i.busy) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/bnum_dp.sv =====
// Datapath for the nearest unique barcode match block: settings, whitelist
// memory, scan counter, distance stage, best tracker and result register.
// Depends on bnum_pkg and bnum_ram.
module bnum_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bnum_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bnum_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  bnum_pkg::in_req_t                   in_req_i,
  input  bnum_pkg::dp_cmd_t                   cmd_i,
  output bnum_pkg::dp_sts_t                   sts_o,
  output bnum_pkg::out_rsp_t                  out_rsp_o
);

  localparam int unsigned AW = bnum_pkg::ADDR_W;
  localparam int unsigned CW = bnum_pkg::CNT_W;
  localparam int unsigned MW = bnum_pkg::CMP_W;
  localparam int unsigned DW = bnum_pkg::DIST_W;
  localparam int unsigned BW = bnum_pkg::BARCODE_W;
  localparam int unsigned SW = bnum_pkg::BASE_W;
  localparam int unsigned NB = bnum_pkg::BARCODE_BASES;

  logic [DW-1:0]                     max_dist_q;
  logic [bnum_pkg::ENTRIES_W-1:0]    entries_q;
  logic [BW-1:0]                     query_q;
  logic [CW-1:0]                     count_q;
  logic [CW-1:0]                     scan_q;
  logic                              v1_q, v2_q;
  logic [AW-1:0]                     idx1_q, idx2_q;
  logic [DW-1:0]                     dist_q;
  logic                              have_q, tie_q;
  logic [DW-1:0]                     best_q;
  logic [AW-1:0]                     best_idx_q;
  bnum_pkg::out_rsp_t                rsp_q;

  logic [BW-1:0]                     rdata;
  logic [NB-1:0]                     mismatch;
  logic [MW-1:0]                     entries_ext;
  logic [MW-1:0]                     depth_ext;
  logic [MW-1:0]                     slot_ext;
  logic                              write_en;
  logic                              in_range;
  logic                              found;

  assign entries_ext = MW'(entries_q);
  assign depth_ext   = MW'(bnum_pkg::TABLE_DEPTH);
  assign slot_ext    = MW'(in_req_i.entry_index);
  assign write_en    = cmd_i.write && (slot_ext < depth_ext);

  bnum_ram #(
    .WIDTH (BW),
    .DEPTH (bnum_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (write_en),
    .waddr_i (AW'(in_req_i.entry_index)),
    .wdata_i (in_req_i.barcode_bases),
    .re_i    (cmd_i.issue),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      mismatch[i] = (query_q[i*SW +: SW] != rdata[i*SW +: SW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= bnum_pkg::MAX_DIST_RESET;
      entries_q  <= bnum_pkg::ENTRIES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bnum_pkg::REG_MAX_DISTANCE:   max_dist_q <= cfg_data_i[DW-1:0];
        bnum_pkg::REG_ENTRIES_IN_USE: entries_q  <= cfg_data_i[bnum_pkg::ENTRIES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  assign in_range = (dist_q <= max_dist_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      query_q <= in_req_i.barcode_bases;
      count_q <= CW'((entries_ext > depth_ext) ? depth_ext : entries_ext);
      scan_q  <= '0;
      have_q  <= 1'b0;
      tie_q   <= 1'b0;
      best_q  <= '0;
      best_idx_q <= '0;
    end else begin
      if (cmd_i.issue) begin
        scan_q <= scan_q + CW'(1);
      end
      if (v2_q && in_range) begin
        if (!have_q || (dist_q < best_q)) begin
          have_q     <= 1'b1;
          tie_q      <= 1'b0;
          best_q     <= dist_q;
          best_idx_q <= idx2_q;
        end else if (dist_q == best_q) begin
          tie_q <= 1'b1;
        end
      end
    end
    idx1_q <= scan_q[AW-1:0];
    idx2_q <= idx1_q;
    dist_q <= DW'($countones(mismatch));
    if (cmd_i.load_out) begin
      rsp_q <= '{match_found:   found,
                 match_index:   found ? bnum_pkg::INDEX_W'(best_idx_q) : '0,
                 best_distance: found ? best_q : '0};
    end
  end

  assign found = have_q && !tie_q;

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.last_issue = ((scan_q + CW'(1)) == count_q);
  assign sts_o.busy       = v1_q || v2_q;
  assign out_rsp_o        = rsp_q;

endmodule
